/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Define ASSERT_OFF to drop them all.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

/* rtl/lpr_pkg.sv */
// ---------------------------------------------------------------------------
// LRU page replacement package
// Sizes and the structs passed along the frame cell chain.
// ---------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int RANK_W     = FRAME_W;
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int FAULT_W    = 16;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

  // Search state handed from one cell to the next.
  typedef struct packed {
    logic                 found;
    logic [FRAME_W-1:0]   hit_idx;
    logic [RANK_W-1:0]    hit_rank;
    logic [RANK_W-1:0]    best_rank;
    logic [FRAME_W-1:0]   best_idx;
    logic [PAGE_BITS-1:0] best_page;
  } lpr_chain_t;

  // Update broadcast to every cell at the end of a lookup.
  typedef struct packed {
    logic               touch;    // make target most recent, age newer ones
    logic               fill;     // claim target as new valid frame, age all
    logic               load;     // write key into target
    logic [FRAME_W-1:0] target;
    logic [RANK_W-1:0]  old_rank;
  } lpr_cmd_t;

endpackage

`default_nettype wire

/* rtl/lru_page_replacement_core.sv */
// ---------------------------------------------------------------------------
// LRU page replacement core
// Resident page table with true least-recently-used replacement.
// ---------------------------------------------------------------------------
// One page reference is taken per clock: raise start with page while busy is
// low, and the result appears on the next cycle with done high for exactly
// that one cycle; the receiver cannot stall it, so capture it then. Every
// reference is handled by the single lookup-and-update pass through the row
// of frame cells (match and oldest-frame search ripple from frame 0 upward,
// the update lands on all cells at the same edge). busy is high only in reset
// and in the cycle after it. The user must write frames_in_use via cfg_we and
// cfg_data only while no reference is in flight; the block does not enforce
// it. 0 acts as 1 and values above the frame count act as the frame count.
`default_nettype none
`include "assert_macros.svh"

module lru_page_replacement_core
  import lpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] page,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic        hit,
  output logic [2:0]  frame,
  output logic        evicted_valid,
  output logic [15:0] evicted_page,
  output logic [15:0] fault_count
);

  logic [3:0]           frames_in_use;
  logic [CNT_W-1:0]     frames_filled;
  logic [FAULT_W-1:0]   faults_total;
  logic                 reset_hold;

  logic                 accept;
  logic [CNT_W-1:0]     n_eff;
  logic [PAGE_BITS-1:0] key;
  lpr_chain_t           chain [MAX_FRAMES+1];
  lpr_chain_t           res;
  lpr_cmd_t             cmd;
  logic [MAX_FRAMES-1:0] valid_vec;
  logic                 do_fill;
  logic                 do_evict;
  logic [FRAME_W-1:0]   target;
  logic [FAULT_W-1:0]   faults_next;

  assign busy   = rst | reset_hold;
  assign accept = start & ~busy;
  assign key    = PAGE_BITS'(page);

  always_comb begin
    if (frames_in_use == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(frames_in_use) > 32'(MAX_FRAMES)) begin
      n_eff = CNT_W'(MAX_FRAMES);
    end else begin
      n_eff = CNT_W'(frames_in_use);
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    lpr_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .idx   (FRAME_W'(i)),
      .n     (n_eff),
      .key   (key),
      .cmd   (cmd),
      .cin   (chain[i]),
      .cout  (chain[i+1]),
      .valid (valid_vec[i])
    );
  end

  assign res = chain[MAX_FRAMES];

  always_comb begin
    do_fill  = !res.found && (frames_filled < n_eff);
    do_evict = !res.found && !do_fill;
    if (res.found) begin
      target = res.hit_idx;
    end else if (do_fill) begin
      target = FRAME_W'(frames_filled);
    end else begin
      target = res.best_idx;
    end
    cmd.touch    = accept && (res.found || do_evict);
    cmd.fill     = accept && do_fill;
    cmd.load     = accept && !res.found;
    cmd.target   = target;
    cmd.old_rank = res.found ? res.hit_rank : res.best_rank;
    if (!res.found && faults_total != FAULT_MAX) begin
      faults_next = faults_total + 1'b1;
    end else begin
      faults_next = faults_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= 4'(MAX_FRAMES);
      frames_filled <= '0;
      faults_total  <= '0;
      reset_hold    <= 1'b1;
      done          <= 1'b0;
    end else begin
      reset_hold <= 1'b0;
      done       <= accept;
      if (cfg_we) begin
        frames_in_use <= cfg_data;
      end
      if (accept) begin
        faults_total <= faults_next;
        if (do_fill) begin
          frames_filled <= CNT_W'(frames_filled + 1'b1);
        end
      end
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (accept) begin
      hit           <= res.found;
      frame         <= 3'(target);
      evicted_valid <= do_evict;
      evicted_page  <= do_evict ? 16'(res.best_page) : '0;
      fault_count   <= 16'(faults_next);
    end
  end

  `ASSERT_CLK(a_done_after_accept, clk, rst, accept |=> done, "result beat missing after accept")
  `ASSERT_CLK(a_no_spurious_done, clk, rst, !accept |=> !done, "result beat without accepted reference")
  `ASSERT_CLK(a_fill_count, clk, rst, $countones(valid_vec) == int'(frames_filled), "valid frames disagree with fill count")
  `ASSERT_NEVER(a_hit_no_evict, clk, rst, done && hit && evicted_valid, "eviction reported on a hit")
  `ASSERT_CLK(a_evict_when_full, clk, rst, accept && do_evict |-> frames_filled >= n_eff, "eviction while a free frame remains")

endmodule

`default_nettype wire

/* rtl/lpr_cell.sv */
// ---------------------------------------------------------------------------
// LRU frame cell
// Holds one frame's page, valid bit and recency rank; extends the search
// chain with its own match and victim candidate and applies the update.
// ---------------------------------------------------------------------------
`default_nettype none

module lpr_cell
  import lpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [FRAME_W-1:0]   idx,
  input  logic [CNT_W-1:0]     n,
  input  logic [PAGE_BITS-1:0] key,
  input  lpr_cmd_t             cmd,
  input  lpr_chain_t           cin,
  output lpr_chain_t           cout,
  output logic                 valid
);

  logic [PAGE_BITS-1:0] page;
  logic [RANK_W-1:0]    rank;
  logic                 usable;
  logic                 is_tgt;

  assign usable = CNT_W'(idx) < n;
  assign is_tgt = cmd.target == idx;

  always_comb begin
    cout = cin;
    // first usable match wins
    if (!cin.found && usable && valid && page == key) begin
      cout.found    = 1'b1;
      cout.hit_idx  = idx;
      cout.hit_rank = rank;
    end
    // frame 0 is the default victim; later frames take over only when older
    if (usable && valid && (rank > cin.best_rank || idx == '0)) begin
      cout.best_rank = rank;
      cout.best_idx  = idx;
      cout.best_page = page;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (cmd.fill) begin
      if (is_tgt) begin
        valid <= 1'b1;
        rank  <= '0;
      end else if (valid) begin
        rank <= RANK_W'(rank + 1'b1);
      end
    end else if (cmd.touch) begin
      if (is_tgt) begin
        rank <= '0;
      end else if (valid && rank < cmd.old_rank) begin
        rank <= RANK_W'(rank + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && is_tgt) begin
      page <= key;
    end
  end

endmodule

`default_nettype wire

/* dv/lru_page_replacement_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LRU page replacement checker
// Watches the reference and result channels of the core, keeps its own copy
// of the resident page table, and compares every result beat field by field
// against the oldest predicted lookup.
// ---------------------------------------------------------------------------

module lru_page_replacement_checker
  import lpr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] page,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        done,
  input  logic        hit,
  input  logic [2:0]  frame,
  input  logic        evicted_valid,
  input  logic [15:0] evicted_page,
  input  logic [15:0] fault_count,
  output int          mismatches,
  output int          pending
);

  typedef struct packed {
    logic                 hit;
    logic [FRAME_W-1:0]   frame;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    logic [FAULT_W-1:0]   faults;
  } lookup_t;

  logic [PAGE_BITS-1:0] resident_page  [MAX_FRAMES];
  logic                 resident_valid [MAX_FRAMES];
  logic [RANK_W-1:0]    age_rank       [MAX_FRAMES];
  logic [CNT_W-1:0]     filled_cnt;
  logic [FAULT_W-1:0]   fault_tally;
  logic [3:0]           frames_cfg;

  lookup_t awaited_lookups [$];

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  task automatic report(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void clear_table();
    for (int i = 0; i < MAX_FRAMES; i++) begin
      resident_page[i]  = '0;
      resident_valid[i] = 1'b0;
      age_rank[i]       = '0;
    end
    filled_cnt  = '0;
    fault_tally = '0;
    frames_cfg  = 4'd8;
  endfunction

  // Make frame f most recent; valid frames newer than it age by one.
  function automatic void promote(input int f);
    logic [RANK_W-1:0] old_rank;
    old_rank = age_rank[f];
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (resident_valid[i] && i != f && age_rank[i] < old_rank)
        age_rank[i] = age_rank[i] + 1'b1;
    end
    age_rank[f] = '0;
  endfunction

  function automatic lookup_t predict_lookup(input logic [PAGE_BITS-1:0] pg);
    lookup_t r;
    int      usable;
    int      f;
    int      best;
    logic    found;
    r      = '0;
    usable = frames_cfg;
    if (usable == 0) usable = 1;
    if (usable > MAX_FRAMES) usable = MAX_FRAMES;
    found = 1'b0;
    f     = 0;
    // Frames at or above the usable count are never matched.
    for (int i = 0; i < usable; i++) begin
      if (!found && resident_valid[i] && resident_page[i] == pg) begin
        f     = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      promote(f);
    end else begin
      if (fault_tally != FAULT_MAX) fault_tally = fault_tally + 1'b1;
      if (filled_cnt < usable) begin
        f = filled_cnt;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          if (resident_valid[i]) age_rank[i] = age_rank[i] + 1'b1;
        end
        resident_valid[f] = 1'b1;
        resident_page[f]  = pg;
        age_rank[f]       = '0;
        filled_cnt        = filled_cnt + 1'b1;
      end else begin
        // Oldest usable frame goes; lowest index wins a tie.
        best = 0;
        for (int i = 0; i < usable; i++) begin
          if (resident_valid[i] && age_rank[i] > best) begin
            best = age_rank[i];
            f    = i;
          end
        end
        r.ev_valid       = 1'b1;
        r.ev_page        = resident_page[f];
        resident_page[f] = pg;
        promote(f);
      end
    end
    r.frame  = f[FRAME_W-1:0];
    r.faults = fault_tally;
    return r;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      clear_table();
      awaited_lookups.delete();
    end else begin
      if (done) begin
        if (awaited_lookups.size() == 0) begin
          report("result beat with no lookup outstanding");
        end else begin
          want = awaited_lookups.pop_front();
          if (hit !== want.hit)
            report($sformatf("hit: expected %0d, got %0d", want.hit, hit));
          if (frame !== want.frame)
            report($sformatf("frame: expected %0d, got %0d", want.frame, frame));
          if (evicted_valid !== want.ev_valid)
            report($sformatf("evicted_valid: expected %0d, got %0d",
                             want.ev_valid, evicted_valid));
          if (evicted_page !== want.ev_page)
            report($sformatf("evicted_page: expected %h, got %h",
                             want.ev_page, evicted_page));
          if (fault_count !== want.faults)
            report($sformatf("fault_count: expected %0d, got %0d",
                             want.faults, fault_count));
        end
      end
      if (cfg_we) frames_cfg = cfg_data;
      if (start && !busy) awaited_lookups.push_back(predict_lookup(page));
    end
    pending = awaited_lookups.size();
  end

endmodule

/* dv/lru_page_replacement_core_tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// LRU page replacement core testbench
// Drives page references under several frame counts and sender gap rates,
// drains all outstanding result beats now and then, and lets the checker
// compare every result beat against its own page table.
// ---------------------------------------------------------------------------

module lru_page_replacement_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 10;
  localparam int PHASE_REFS  = 50;

  localparam logic [15:0] DIRECTED_REFS [16] = '{
    16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h0003, 16'h0004,
    16'h0005, 16'h0006, 16'h0000, 16'h0007, 16'hFFFF, 16'h8000, 16'h5555,
    16'hAAAA, 16'h0000
  };
  localparam logic [3:0] PHASE_FRAMES [PHASES] = '{
    4'd3, 4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd9, 4'd5, 4'd7, 4'd4
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [15:0] page = '0;
  logic        cfg_we = 1'b0;
  logic [3:0]  cfg_data = '0;
  logic        busy;
  logic        done;
  logic        hit;
  logic [2:0]  frame;
  logic        evicted_valid;
  logic [15:0] evicted_page;
  logic [15:0] fault_count;

  int mismatches;
  int pending;
  int idle_pct;
  int cycle_count;

  lru_page_replacement_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .page          (page),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .done          (done),
    .hit           (hit),
    .frame         (frame),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
  );

  lru_page_replacement_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .page          (page),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .done          (done),
    .hit           (hit),
    .frame         (frame),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count),
    .mismatches    (mismatches),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hold start low for random gaps, then present one reference until taken.
  task automatic send_ref(input logic [15:0] pg);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    page  <= pg;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every result beat has come back.
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic write_frames(input logic [3:0] value);
    settle();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Mostly draw from a small working set so hits and evictions both show up.
  task automatic run_phase(input int refs, input logic [3:0] frames_set);
    logic [15:0] working_set [16];
    int          set_len;
    logic [15:0] pg;
    set_len = (frames_set == 0) ? 1 : ((frames_set > 8) ? 8 : int'(frames_set));
    set_len += $urandom_range(0, 5);
    for (int i = 0; i < set_len; i++) begin
      case ($urandom_range(7))
        0:       working_set[i] = 16'h0000;
        1:       working_set[i] = 16'hFFFF;
        default: working_set[i] = 16'($urandom);
      endcase
    end
    for (int n = 0; n < refs; n++) begin
      if ($urandom_range(99) < 85) pg = working_set[$urandom_range(set_len - 1)];
      else pg = 16'($urandom);
      send_ref(pg);
      if ($urandom_range(99) < 2) settle();
    end
  endtask

  initial begin
    idle_pct = 33;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset frame count first, then a single frame, then an oversized count.
    foreach (DIRECTED_REFS[i]) send_ref(DIRECTED_REFS[i]);
    write_frames(4'd0);
    send_ref(16'h1234);
    send_ref(16'h1234);
    send_ref(16'h4321);
    send_ref(16'h1234);
    write_frames(4'd15);
    send_ref(16'hFFFF);
    send_ref(16'h4321);
    send_ref(16'h0001);

    for (int p = 0; p < PHASES; p++) begin
      logic [3:0] frames_set;
      frames_set = (p == PHASES - 1) ? 4'($urandom_range(15)) : PHASE_FRAMES[p];
      idle_pct   = (p < 4) ? 33 : ((p < 7) ? 52 : 0);
      write_frames(frames_set);
      run_phase(PHASE_REFS, frames_set);
    end

    write_frames(4'd8);
    idle_pct = 0;
    run_phase(20, 4'd8);

    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("lru_page_replacement_core test passed");
    end else begin
      $display("lru_page_replacement_core test failed");
    end
    $finish;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("lru_page_replacement_core test failed");
    $finish;
  end

endmodule
